// ===== design/arrenum_pkg.sv =====
package arrenum_pkg;

    localparam int MAX_POOL_DEF = 16;
    localparam int MAX_PICK_DEF = 8;

    // result lanes shown on the ports
    localparam int LANES      = 8;
    localparam int OUT_W      = 5;
    localparam int POOL_W     = 5;
    localparam int PICK_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_POOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PICK = 2'd1;

    localparam logic [POOL_W-1:0] POOL_RST = 5'd16;
    localparam logic [PICK_W-1:0] PICK_RST = 4'd1;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_BAD = 2'd1,
        STAT_EXH = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_RESTART   = 4'd1,
        OP_ORD_FIND  = 4'd2,
        OP_ORD_SWAP  = 4'd3,
        OP_ORD_REV   = 4'd4,
        OP_MASK_FIND = 4'd5,
        OP_MASK_SWAP = 4'd6,
        OP_MASK_REV  = 4'd7,
        OP_LOAD_STEP = 4'd8,
        OP_OUT       = 4'd9
    } op_t;

    typedef struct packed {
        logic [POOL_W-1:0] pool;
        logic [PICK_W-1:0] pick;
    } cfg_t;

    typedef struct packed {
        op_t     op;
        status_t stat;
    } cmd_t;

    typedef struct packed {
        logic ord_found;
        logic mask_found;
        logic load_done;
        logic at_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/arrangement_enumerator.sv =====
// Arrangement enumerator: each request beat on the input returns one result beat holding the
// next ordered choice of pick_count distinct values from 1..pool_size, lexicographic within
// one selection, selections stepping from the lowest positions toward the highest. A request
// with restart set, or the first one after reset or a pool or pick write, returns the ascending
// arrangement 1..p. The last arrangement carries is_last; later requests report exhausted,
// and a bad setting (p = 0, n = 0, p > n or beyond the built maximums) reports an error with
// all lanes 0. A restart, error or exhausted request goes straight to the output step; the next
// ordering of the same selection passes through the order find, swap and reverse steps; and
// when the selection moves on, the mask find, swap and reverse steps are followed by a gather
// that fills the lanes one selected position per cycle. Each result is loaded once the output
// register is free. A new request is taken the cycle after the result is loaded, while that
// result may still wait on the output.
module arrangement_enumerator #(
    parameter int MAX_POOL = arrenum_pkg::MAX_POOL_DEF,
    parameter int MAX_PICK = arrenum_pkg::MAX_PICK_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [arrenum_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arrenum_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 restart,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [arrenum_pkg::OUT_W-1:0]        value_1,
    output logic [arrenum_pkg::OUT_W-1:0]        value_2,
    output logic [arrenum_pkg::OUT_W-1:0]        value_3,
    output logic [arrenum_pkg::OUT_W-1:0]        value_4,
    output logic [arrenum_pkg::OUT_W-1:0]        value_5,
    output logic [arrenum_pkg::OUT_W-1:0]        value_6,
    output logic [arrenum_pkg::OUT_W-1:0]        value_7,
    output logic [arrenum_pkg::OUT_W-1:0]        value_8,
    output logic                                 is_last,
    output logic [1:0]                           status
);

    arrenum_pkg::cfg_t     cfg;
    arrenum_pkg::cmd_t     cmd;
    arrenum_pkg::dp_stat_t st;
    logic [arrenum_pkg::LANES-1:0][arrenum_pkg::OUT_W-1:0] out_val;

    arrenum_ctrl #(
        .MAX_POOL (MAX_POOL),
        .MAX_PICK (MAX_PICK)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .cfg       (cfg),
        .cmd       (cmd),
        .st        (st)
    );

    arrenum_datapath #(
        .MAX_POOL (MAX_POOL),
        .MAX_PICK (MAX_PICK)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .st        (st),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_val   (out_val),
        .is_last   (is_last),
        .status    (status)
    );

    assign value_1 = out_val[0];
    assign value_2 = out_val[1];
    assign value_3 = out_val[2];
    assign value_4 = out_val[3];
    assign value_5 = out_val[4];
    assign value_6 = out_val[5];
    assign value_7 = out_val[6];
    assign value_8 = out_val[7];

endmodule

// ===== design/arrenum_datapath.sv =====
module arrenum_datapath #(
    parameter int MAX_POOL = arrenum_pkg::MAX_POOL_DEF,
    parameter int MAX_PICK = arrenum_pkg::MAX_PICK_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  arrenum_pkg::cfg_t                                      cfg,
    input  arrenum_pkg::cmd_t                                      cmd,
    output arrenum_pkg::dp_stat_t                                  st,
    input  logic                                                   out_stall,
    output logic                                                   out_valid,
    output logic [arrenum_pkg::LANES-1:0][arrenum_pkg::OUT_W-1:0]  out_val,
    output logic                                                   is_last,
    output logic [1:0]                                             status
);

    localparam int VAL_W = $clog2(MAX_POOL + 1);
    localparam int OW    = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
    localparam int PW    = $clog2(MAX_POOL);
    localparam int KW    = $clog2(MAX_PICK + 1);

    logic [MAX_POOL-1:0] mask_reg, mask_next;
    logic [MAX_POOL-1:0] scratch_reg, scratch_next;
    logic [VAL_W-1:0]    ord_reg [MAX_PICK];
    logic [VAL_W-1:0]    ord_next [MAX_PICK];
    logic [OW-1:0]       opiv_reg, opiv_next;
    logic                ofound_reg, ofound_next;
    logic [PW-1:0]       mpiv_reg, mpiv_next;
    logic                mfound_reg, mfound_next;
    logic [KW-1:0]       cnt_reg, cnt_next;

    logic                      out_valid_reg;
    logic [arrenum_pkg::LANES-1:0][arrenum_pkg::OUT_W-1:0] out_val_reg;
    logic                      is_last_reg;
    arrenum_pkg::status_t      out_stat_reg;

    logic                o_hit;
    logic [OW-1:0]       o_idx;
    logic [OW-1:0]       o_sw;
    logic                m_hit;
    logic [PW-1:0]       m_idx;
    logic [PW-1:0]       m_sw;
    logic [MAX_POOL-1:0] mask_rev;
    logic [PW-1:0]       low_pos;
    logic                last_mask_ok;
    logic                desc_ok;
    logic [arrenum_pkg::LANES-1:0][arrenum_pkg::OUT_W-1:0] lane_val;

    // searches over the stored order and mask
    always_comb
    begin
        int src_m;
        int lm_lo;
        o_hit   = 1'b0;
        o_idx   = '0;
        o_sw    = '0;
        m_hit   = 1'b0;
        m_idx   = '0;
        m_sw    = '0;
        low_pos = '0;
        desc_ok = 1'b1;
        last_mask_ok = 1'b1;
        lm_lo   = int'(cfg.pool) - int'(cfg.pick);

        for (int i = 0; i < MAX_PICK - 1; i++)
        begin
            if (i + 2 <= int'(cfg.pick) && ord_reg[i] < ord_reg[i + 1])
            begin
                o_hit = 1'b1;
                o_idx = OW'(i);
            end
            if (i + 2 <= int'(cfg.pick) && !(ord_reg[i] > ord_reg[i + 1]))
                desc_ok = 1'b0;
        end

        for (int j = 0; j < MAX_PICK; j++)
        begin
            if (j < int'(cfg.pick) && ord_reg[j] > ord_reg[opiv_reg])
                o_sw = OW'(j);
        end

        for (int i = 0; i < MAX_POOL - 1; i++)
        begin
            if (i + 2 <= int'(cfg.pool) && mask_reg[i] && !mask_reg[i + 1])
            begin
                m_hit = 1'b1;
                m_idx = PW'(i);
            end
        end

        for (int j = 0; j < MAX_POOL; j++)
        begin
            if (j < int'(cfg.pool) && !mask_reg[j])
                m_sw = PW'(j);
        end

        // mirror the positions above the pivot into the top of the pool
        for (int k = 0; k < MAX_POOL; k++)
        begin
            src_m = int'(cfg.pool) + int'(mpiv_reg) - k;
            if (k > int'(mpiv_reg) && k < int'(cfg.pool))
                mask_rev[k] = mask_reg[src_m[PW-1:0]];
            else
                mask_rev[k] = mask_reg[k];
        end

        for (int i = MAX_POOL - 1; i >= 0; i--)
        begin
            if (scratch_reg[i])
                low_pos = PW'(i);
        end

        for (int k = 0; k < MAX_POOL; k++)
        begin
            if (mask_reg[k] != (k >= lm_lo && k < int'(cfg.pool)))
                last_mask_ok = 1'b0;
        end
    end

    always_comb
    begin
        int src_o;
        mask_next    = mask_reg;
        scratch_next = scratch_reg;
        ord_next     = ord_reg;
        opiv_next    = opiv_reg;
        ofound_next  = ofound_reg;
        mpiv_next    = mpiv_reg;
        mfound_next  = mfound_reg;
        cnt_next     = cnt_reg;
        src_o        = 0;

        case (cmd.op)
            arrenum_pkg::OP_RESTART:
            begin
                for (int k = 0; k < MAX_POOL; k++)
                    mask_next[k] = (k < int'(cfg.pick));
                for (int k = 0; k < MAX_PICK; k++)
                    ord_next[k] = (k < int'(cfg.pick)) ? VAL_W'(k + 1) : '0;
            end
            arrenum_pkg::OP_ORD_FIND:
            begin
                opiv_next   = o_idx;
                ofound_next = o_hit;
            end
            arrenum_pkg::OP_ORD_SWAP:
            begin
                ord_next[opiv_reg] = ord_reg[o_sw];
                ord_next[o_sw]     = ord_reg[opiv_reg];
            end
            arrenum_pkg::OP_ORD_REV:
            begin
                for (int k = 0; k < MAX_PICK; k++)
                begin
                    src_o = int'(cfg.pick) + int'(opiv_reg) - k;
                    if (k > int'(opiv_reg) && k < int'(cfg.pick))
                        ord_next[k] = ord_reg[src_o[OW-1:0]];
                end
            end
            arrenum_pkg::OP_MASK_FIND:
            begin
                mpiv_next   = m_idx;
                mfound_next = m_hit;
            end
            arrenum_pkg::OP_MASK_SWAP:
            begin
                mask_next[mpiv_reg] = 1'b0;
                mask_next[m_sw]     = 1'b1;
            end
            arrenum_pkg::OP_MASK_REV:
            begin
                mask_next    = mask_rev;
                scratch_next = mask_rev;
                cnt_next     = '0;
                for (int k = 0; k < MAX_PICK; k++)
                    ord_next[k] = '0;
            end
            arrenum_pkg::OP_LOAD_STEP:
            begin
                // take the lowest selected position into the next lane
                ord_next[cnt_reg[OW-1:0]] = VAL_W'(int'(low_pos) + 1);
                scratch_next = scratch_reg & (scratch_reg - 1'b1);
                cnt_next     = cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mask_reg    <= mask_next;
        scratch_reg <= scratch_next;
        ord_reg     <= ord_next;
        opiv_reg    <= opiv_next;
        ofound_reg  <= ofound_next;
        mpiv_reg    <= mpiv_next;
        mfound_reg  <= mfound_next;
        cnt_reg     <= cnt_next;
    end

    genvar l;
    generate
        for (l = 0; l < arrenum_pkg::LANES; l++)
        begin : g_lane
            if (l < MAX_PICK)
            begin : g_used
                assign lane_val[l] = (l < int'(cfg.pick)) ?
                                     arrenum_pkg::OUT_W'(ord_reg[l]) : '0;
            end
            else
            begin : g_unused
                assign lane_val[l] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == arrenum_pkg::OP_OUT)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == arrenum_pkg::OP_OUT)
        begin
            out_stat_reg <= cmd.stat;
            if (cmd.stat == arrenum_pkg::STAT_OK)
            begin
                out_val_reg <= lane_val;
                is_last_reg <= last_mask_ok && desc_ok;
            end
            else
            begin
                out_val_reg <= '0;
                is_last_reg <= 1'b0;
            end
        end
    end

    assign st.ord_found  = ofound_reg;
    assign st.mask_found = mfound_reg;
    assign st.load_done  = (scratch_reg == '0) || (cnt_reg == KW'(MAX_PICK));
    assign st.at_last    = last_mask_ok && desc_ok;
    assign st.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_val   = out_val_reg;
    assign is_last   = is_last_reg;
    assign status    = out_stat_reg;

endmodule

// ===== design/arrenum_ctrl.sv =====
module arrenum_ctrl #(
    parameter int MAX_POOL = arrenum_pkg::MAX_POOL_DEF,
    parameter int MAX_PICK = arrenum_pkg::MAX_PICK_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [arrenum_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arrenum_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 restart,
    output arrenum_pkg::cfg_t                    cfg,
    output arrenum_pkg::cmd_t                    cmd,
    input  arrenum_pkg::dp_stat_t                st
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_ORD_SWAP  = 8'b0000_0010,
        S_ORD_REV   = 8'b0000_0100,
        S_MASK_SWAP = 8'b0000_1000,
        S_MASK_REV  = 8'b0001_0000,
        S_LOAD      = 8'b0010_0000,
        S_DONE      = 8'b0100_0000,
        S_SPARE     = 8'b1000_0000
    } state_t;

    state_t                              state_reg, state_next;
    logic [arrenum_pkg::POOL_W-1:0]      pool_reg;
    logic [arrenum_pkg::PICK_W-1:0]      pick_reg;
    logic                                started_reg, started_next;
    logic                                exh_reg, exh_next;
    arrenum_pkg::status_t                stat_reg, stat_next;
    logic                                bad_cfg;

    assign bad_cfg = (pick_reg == '0) || (pool_reg == '0)
                  || (arrenum_pkg::POOL_W'(pick_reg) > pool_reg)
                  || (int'(pool_reg) > MAX_POOL)
                  || (int'(pick_reg) > MAX_PICK);

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        exh_next     = exh_reg;
        stat_next    = stat_reg;
        cmd.op       = arrenum_pkg::OP_NONE;
        cmd.stat     = stat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DONE;
                    if (bad_cfg)
                        stat_next = arrenum_pkg::STAT_BAD;
                    else if (restart || !started_reg)
                    begin
                        cmd.op       = arrenum_pkg::OP_RESTART;
                        started_next = 1'b1;
                        exh_next     = 1'b0;
                        stat_next    = arrenum_pkg::STAT_OK;
                    end
                    else if (exh_reg)
                        stat_next = arrenum_pkg::STAT_EXH;
                    else
                    begin
                        cmd.op     = arrenum_pkg::OP_ORD_FIND;
                        stat_next  = arrenum_pkg::STAT_OK;
                        state_next = S_ORD_SWAP;
                    end
                end
            end
            S_ORD_SWAP:
            begin
                if (st.ord_found)
                begin
                    cmd.op     = arrenum_pkg::OP_ORD_SWAP;
                    state_next = S_ORD_REV;
                end
                else
                begin
                    // orderings used up: advance the selection mask
                    cmd.op     = arrenum_pkg::OP_MASK_FIND;
                    state_next = S_MASK_SWAP;
                end
            end
            S_ORD_REV:
            begin
                cmd.op     = arrenum_pkg::OP_ORD_REV;
                state_next = S_DONE;
            end
            S_MASK_SWAP:
            begin
                if (st.mask_found)
                begin
                    cmd.op     = arrenum_pkg::OP_MASK_SWAP;
                    state_next = S_MASK_REV;
                end
                else
                begin
                    exh_next   = 1'b1;
                    stat_next  = arrenum_pkg::STAT_EXH;
                    state_next = S_DONE;
                end
            end
            S_MASK_REV:
            begin
                cmd.op     = arrenum_pkg::OP_MASK_REV;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (st.load_done)
                    state_next = S_DONE;
                else
                    cmd.op = arrenum_pkg::OP_LOAD_STEP;
            end
            S_DONE:
            begin
                // hold until the output register can take the beat
                if (st.out_free)
                begin
                    cmd.op = arrenum_pkg::OP_OUT;
                    if (stat_reg == arrenum_pkg::STAT_OK && st.at_last)
                        exh_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write && (cfg_index inside {arrenum_pkg::REG_POOL, arrenum_pkg::REG_PICK}))
        begin
            started_next = 1'b0;
            exh_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pool_reg    <= arrenum_pkg::POOL_RST;
            pick_reg    <= arrenum_pkg::PICK_RST;
            started_reg <= 1'b0;
            exh_reg     <= 1'b0;
            stat_reg    <= arrenum_pkg::STAT_OK;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            exh_reg     <= exh_next;
            stat_reg    <= stat_next;
            if (cfg_write && cfg_index == arrenum_pkg::REG_POOL)
                pool_reg <= cfg_data[arrenum_pkg::POOL_W-1:0];
            if (cfg_write && cfg_index == arrenum_pkg::REG_PICK)
                pick_reg <= cfg_data[arrenum_pkg::PICK_W-1:0];
        end
    end

    assign cfg.pool = pool_reg;
    assign cfg.pick = pick_reg;

endmodule

// ===== design/arrenum_checker.sv =====
module arrenum_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [arrenum_pkg::OUT_W-1:0]  value_1,
    input logic [arrenum_pkg::OUT_W-1:0]  value_2,
    input logic [arrenum_pkg::OUT_W-1:0]  value_3,
    input logic [arrenum_pkg::OUT_W-1:0]  value_4,
    input logic [arrenum_pkg::OUT_W-1:0]  value_5,
    input logic [arrenum_pkg::OUT_W-1:0]  value_6,
    input logic [arrenum_pkg::OUT_W-1:0]  value_7,
    input logic [arrenum_pkg::OUT_W-1:0]  value_8,
    input logic                           is_last,
    input logic [1:0]                     status
);

    // one request at a time: a taken beat closes the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after an accepted beat");

    // error and exhausted beats carry no arrangement
    a_blank_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != arrenum_pkg::STAT_OK |->
            value_1 == '0 && value_2 == '0 && value_3 == '0 && value_4 == '0 &&
            value_5 == '0 && value_6 == '0 && value_7 == '0 && value_8 == '0 &&
            !is_last)
        else $error("failed beat shows lane data");

    a_distinct_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == arrenum_pkg::STAT_OK |->
            value_1 != value_2 || value_2 == '0)
        else $error("first two lanes repeat a value");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(value_1) && $stable(value_8) &&
            $stable(is_last) && $stable(status))
        else $error("stalled result beat changed");

endmodule

bind arrangement_enumerator arrenum_checker u_arrenum_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_1   (value_1),
    .value_2   (value_2),
    .value_3   (value_3),
    .value_4   (value_4),
    .value_5   (value_5),
    .value_6   (value_6),
    .value_7   (value_7),
    .value_8   (value_8),
    .is_last   (is_last),
    .status    (status)
);

// ===== dv/arrangement_enumerator_tb.sv =====
module arrangement_enumerator_tb;
    import arrenum_pkg::*;

    localparam int MAX_POOL = MAX_POOL_DEF;
    localparam int MAX_PICK = MAX_PICK_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES = 300;

    // indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [LANES-1:0][OUT_W-1:0] lane;
        logic                        last;
        status_t                     stat;
    } arrangement_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_POOL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic restart = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [OUT_W-1:0] value_1, value_2, value_3, value_4;
    logic [OUT_W-1:0] value_5, value_6, value_7, value_8;
    logic is_last;
    logic [1:0] status;

    // requests waiting to be offered, and arrangements waiting to come back
    logic request_q[$];
    arrangement_t arrangement_q[$];

    int gap_pct = 25;
    int stall_pct = 25;
    logic hold_armed = 1'b0;
    int hold_left = 0;
    logic hold_used = 1'b0;
    int fail_cnt = 0;
    int tick_count = 0;

    // settings as last written, and the enumeration state that follows them
    logic [POOL_W-1:0] pool_n = POOL_RST;
    logic [PICK_W-1:0] pick_p = PICK_RST;
    int cfg_epoch = 0;
    int applied_epoch = 0;
    logic [MAX_POOL-1:0] sel_mask = MAX_POOL'(1);
    logic [OUT_W-1:0] ord [MAX_PICK] = '{default: '0};
    logic running = 1'b0;
    logic spent = 1'b0;

    arrangement_enumerator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value_1   (value_1),
        .value_2   (value_2),
        .value_3   (value_3),
        .value_4   (value_4),
        .value_5   (value_5),
        .value_6   (value_6),
        .value_7   (value_7),
        .value_8   (value_8),
        .is_last   (is_last),
        .status    (status)
    );

    always #6 clk = ~clk;

    function automatic arrangement_t advance_enum(input logic rs);
        arrangement_t r;
        int n, p, i, j, a, b, k;
        logic [OUT_W-1:0] t;
        logic [MAX_POOL-1:0] m;
        logic [MAX_POOL-1:0] tail_m;
        logic reload;
        r = '0;
        r.stat = STAT_OK;
        reload = 1'b0;
        n = int'(pool_n);
        p = int'(pick_p);
        if (cfg_epoch != applied_epoch)
        begin
            running = 1'b0;
            spent = 1'b0;
            applied_epoch = cfg_epoch;
        end
        if (p == 0 || n == 0 || p > n || n > MAX_POOL || p > MAX_PICK)
        begin
            r.stat = STAT_BAD;
            return r;
        end
        if (rs || !running)
        begin
            sel_mask = (MAX_POOL'(1) << p) - MAX_POOL'(1);
            running = 1'b1;
            spent = 1'b0;
            reload = 1'b1;
        end
        else if (spent)
        begin
            r.stat = STAT_EXH;
            return r;
        end
        else
        begin
            // next ordering of the selected values
            i = p - 2;
            while (i >= 0 && ord[i] >= ord[i + 1])
                i--;
            if (i >= 0)
            begin
                j = p - 1;
                while (ord[j] <= ord[i])
                    j--;
                t = ord[i];
                ord[i] = ord[j];
                ord[j] = t;
                a = i + 1;
                b = p - 1;
                while (a < b)
                begin
                    t = ord[a];
                    ord[a] = ord[b];
                    ord[b] = t;
                    a++;
                    b--;
                end
            end
            else
            begin
                // orderings used up: step the mask to its previous permutation
                i = n - 2;
                while (i >= 0 && !(sel_mask[i] && !sel_mask[i + 1]))
                    i--;
                if (i < 0)
                begin
                    spent = 1'b1;
                    r.stat = STAT_EXH;
                    return r;
                end
                j = n - 1;
                while (sel_mask[j])
                    j--;
                sel_mask[i] = 1'b0;
                sel_mask[j] = 1'b1;
                m = sel_mask & ((MAX_POOL'(1) << (i + 1)) - MAX_POOL'(1));
                for (a = i + 1; a < n; a++)
                    if (sel_mask[a])
                        m[n - 1 - (a - i - 1)] = 1'b1;
                sel_mask = m;
                reload = 1'b1;
            end
        end
        if (reload)
        begin
            k = 0;
            for (i = 0; i < MAX_PICK; i++)
                ord[i] = '0;
            for (i = 0; i < n; i++)
                if (sel_mask[i] && k < MAX_PICK)
                begin
                    ord[k] = OUT_W'(i + 1);
                    k++;
                end
        end
        tail_m = ((MAX_POOL'(1) << p) - MAX_POOL'(1)) << (n - p);
        r.last = (sel_mask == tail_m);
        for (i = 0; i + 1 < p; i++)
            if (ord[i] <= ord[i + 1])
                r.last = 1'b0;
        if (r.last)
            spent = 1'b1;
        for (k = 0; k < p && k < LANES; k++)
            r.lane[k] = ord[k];
        return r;
    endfunction

    // sender: predict each accepted beat, then offer the next request or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                arrangement_q = {arrangement_q, advance_enum(restart)};
            if (!in_valid || !in_stall)
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    in_valid <= 1'b1;
                    restart <= request_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_armed && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        arrangement_t want;
        logic [LANES-1:0][OUT_W-1:0] seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {value_8, value_7, value_6, value_5, value_4, value_3, value_2, value_1};
            if (arrangement_q.size() == 0)
            begin
                $error("result beat with no arrangement pending");
                fail_cnt++;
            end
            else
            begin
                want = arrangement_q.pop_front();
                for (int k = 0; k < LANES; k++)
                    if (seen[k] !== want.lane[k])
                    begin
                        $error("value_%0d: expected %0d, got %0d", k + 1, want.lane[k], seen[k]);
                        fail_cnt++;
                    end
                if (is_last !== want.last)
                begin
                    $error("is_last: expected %0d, got %0d", want.last, is_last);
                    fail_cnt++;
                end
                if (status !== want.stat)
                begin
                    $error("status: expected %0d, got %0d", want.stat, status);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        tick_count <= tick_count + 1;
        if (tick_count > CYCLE_LIMIT)
        begin
            $display("arrangement_enumerator regression: fail");
            $finish;
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_POOL)
        begin
            pool_n = data;
            cfg_epoch++;
        end
        else if (idx == REG_PICK)
        begin
            pick_p = data[PICK_W-1:0];
            cfg_epoch++;
        end
    endtask

    task automatic configure(input int n, input int p);
        logic hi;
        hi = 1'($urandom_range(0, 1));
        set_reg(REG_POOL, CFG_DATA_W'(n));
        // upper data bit is not part of pick_count
        set_reg(REG_PICK, {hi, PICK_W'(p)});
    endtask

    // wait out every pending request and result, then let the block go quiet;
    // sample at the falling edge so the sender's updates have settled
    task automatic settle();
        while (request_q.size() != 0 || in_valid || arrangement_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_batch(input int count, input int restart_pct);
        for (int i = 0; i < count; i++)
            request_q = {request_q, ($urandom_range(0, 99) < restart_pct)};
        settle();
    endtask

    initial
    begin
        int sel, n, p, total, batch, phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: n = 16, p = 1; first request acts as a restart
        run_batch(3, 0);

        // 3 pick 2: six arrangements, then exhausted twice, restart, next
        configure(3, 2);
        run_batch(8, 0);
        request_q = {request_q, 1'b1};
        request_q = {request_q, 1'b0};
        settle();

        // single value pool: first is also last
        configure(1, 1);
        run_batch(2, 0);

        // bad settings
        configure(16, 0);
        run_batch(1, 100);
        configure(0, 1);
        run_batch(1, 0);
        configure(2, 3);
        run_batch(1, 0);
        configure(17, 1);
        run_batch(1, 0);
        configure(31, 1);
        run_batch(1, 0);
        configure(16, 9);
        run_batch(1, 0);
        configure(16, 15);
        run_batch(1, 0);

        // writes to undecoded indexes leave the enumeration running
        configure(4, 4);
        run_batch(2, 0);
        set_reg(REG_SPARE_LO, 5'h1f);
        set_reg(REG_SPARE_HI, 5'h0a);
        run_batch(1, 0);

        total = 0;
        phase = 0;
        while (total < 900)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                n = $urandom_range(0, 31);
                p = $urandom_range(0, 15);
            end
            else if (sel < 14)
            begin
                n = MAX_POOL;
                p = MAX_PICK;
            end
            else if (sel < 20)
            begin
                n = MAX_POOL;
                p = 1;
            end
            else if (sel < 28)
            begin
                n = $urandom_range(6, MAX_POOL);
                p = $urandom_range(1, 2);
            end
            else
            begin
                n = $urandom_range(1, 5);
                p = $urandom_range(1, n);
            end
            configure(n, p);
            batch = $urandom_range(25, 60);
            gap_pct = 25;
            stall_pct = 25;
            if (phase == 2)
            begin
                // long stretch with back-to-back traffic
                gap_pct = 0;
                stall_pct = 0;
                batch = 120;
            end
            else if (phase == 5)
                hold_armed = 1'b1;
            run_batch(batch, 3);
            total += batch;
            if ($urandom_range(0, 7) == 0)
            begin
                set_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                        CFG_DATA_W'($urandom_range(0, 31)));
                run_batch(10, 3);
                total += 10;
            end
            phase++;
        end

        if (fail_cnt == 0 && arrangement_q.size() == 0)
            $display("arrangement_enumerator regression: pass");
        else
            $display("arrangement_enumerator regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/arrenum_pkg.sv
design/arrenum_datapath.sv
design/arrenum_ctrl.sv
design/arrangement_enumerator.sv
design/arrenum_checker.sv
dv/arrangement_enumerator_tb.sv
